// ----- hdl/modular_arithmetic_unit_defines.svh -----
// Assertion macros for the modular arithmetic unit.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
// Implication check reported through $error.
`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check reported through $error.
`define MAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/mau_pkg.sv -----
// Package with the types, constants and codes of the modular arithmetic unit.
package mau_pkg;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned OPW = 64;
  localparam int unsigned CW = $clog2(OPW + 2);
  localparam logic [WIDTH-1:0] MOD_RESET = WIDTH'(17);

  typedef enum logic [2:0] {
    FN_RED = 3'd0, FN_ADD = 3'd1, FN_SUB = 3'd2, FN_MUL = 3'd3,
    FN_DIV = 3'd4, FN_POW = 3'd5, FN_INV = 3'd6, FN_NEG = 3'd7
  } func_t;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        error;
  } out_item_t;

  typedef enum logic [1:0] {
    DOP_REM = 2'd0, DOP_MUL = 2'd1
  } dop_t;

  typedef struct packed {
    logic       start;
    dop_t       op;
  } du_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RAW, S_RB, S_RBW, S_DISP, S_MULW,
    S_INV_CHK, S_INV_Q, S_INV_QW, S_INV_M, S_INV_MW, S_INV_UPD,
    S_DIV_M, S_DIV_MW, S_POW_BIT, S_POW_AM, S_POW_AMW, S_POW_SQ, S_POW_SQW,
    S_OUT
  } state_t;
endpackage

// ----- hdl/mau_datapath.sv -----
// Shared bit-serial unit: modular remainder of a 64-bit value, or modular product.
module mau_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mau_pkg::du_cmd_t              cmd,
  input  logic [63:0]                   x,
  input  logic [63:0]                   y,
  input  logic [63:0]                   m,
  output logic                          busy,
  output logic [63:0]                   res,
  output logic [63:0]                   quo
);
  import mau_pkg::*;

  dop_t        op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [63:0] q_r, q_nxt;
  logic [64:0] dbl;
  logic [64:0] sum;
  logic [63:0] dred;

  assign busy = busy_r;
  assign res  = acc_r;
  assign quo  = q_r;

  always_comb begin
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    dbl      = '0;
    sum      = '0;
    dred     = '0;
    if (cmd.start) begin
      op_nxt   = cmd.op;
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(OPW);
      acc_nxt  = '0;
      sh_nxt   = y;
      q_nxt    = '0;
      if (cmd.op == DOP_REM) sh_nxt = x;
    end else if (busy_r) begin
      // Restoring division on the remainder path, double-and-add on the product path.
      dbl = {acc_r, (op_r == DOP_REM) ? sh_r[63] : 1'b0};
      if (dbl >= {1'b0, m}) dred = 64'(dbl - {1'b0, m});
      else dred = dbl[63:0];
      if (op_r == DOP_REM) begin
        acc_nxt = dred;
        q_nxt   = {q_r[62:0], (dbl >= {1'b0, m})};
      end else if (sh_r[63]) begin
        sum = {1'b0, dred} + {1'b0, x};
        acc_nxt = (sum >= {1'b0, m}) ? 64'(sum - {1'b0, m}) : sum[63:0];
      end else begin
        acc_nxt = dred;
      end
      sh_nxt  = {sh_r[62:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= DOP_REM;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
  end
endmodule

// ----- hdl/mau_ctrl.sv -----
// Sequencer that runs each operation through the shared unit.
module mau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mau_pkg::out_item_t out_data,
  input  logic [31:0]        modulus,
  output mau_pkg::du_cmd_t   cmd,
  output logic [63:0]        dx,
  output logic [63:0]        dy,
  output logic [63:0]        dm,
  input  logic               dbusy,
  input  logic [63:0]        dres,
  input  logic [63:0]        dquo
);
  import mau_pkg::*;

  state_t      state_r, state_nxt;
  func_t       func_r, func_nxt;
  logic [63:0] ra_r, ra_nxt, rb_r, rb_nxt, eb_r, eb_nxt, m_r, m_nxt;
  logic        aneg_r, aneg_nxt, bneg_r, bneg_nxt;
  logic [63:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [63:0] q_r, q_nxt, rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt, e_r, e_nxt;
  logic        err_r, err_nxt;
  logic [31:0] res_r, res_nxt;
  logic [63:0] neg_a, neg_b, tmp;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{result: res_r, error: err_r};
  assign neg_a = 64'(0) - 64'(in_data.operand_a);
  assign neg_b = 64'(0) - 64'(in_data.operand_b);
  // The Euclid quotient step divides by r1; everything else works modulo m.
  assign dm = (state_r == S_INV_Q || state_r == S_INV_QW) ? r1_r : m_r;

  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r; ra_nxt = ra_r; rb_nxt = rb_r; eb_nxt = eb_r; m_nxt = m_r;
    aneg_nxt = aneg_r; bneg_nxt = bneg_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    q_nxt = q_r; rem_nxt = rem_r; acc_nxt = acc_r; e_nxt = e_r;
    err_nxt = err_r; res_nxt = res_r;
    cmd = '{start: 1'b0, op: DOP_REM};
    dx = '0; dy = '0; tmp = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = func_t'(in_data.func);
          aneg_nxt = in_data.operand_a[63];
          bneg_nxt = in_data.operand_b[63];
          ra_nxt = aneg_nxt ? neg_a : 64'(in_data.operand_a);
          rb_nxt = bneg_nxt ? neg_b : 64'(in_data.operand_b);
          eb_nxt = rb_nxt;
          m_nxt = {32'd0, modulus};
          err_nxt = 1'b0;
          state_nxt = S_RA;
        end
      end
      S_RA: begin
        cmd = '{start: 1'b1, op: DOP_REM}; dx = ra_r; state_nxt = S_RAW;
      end
      S_RAW: begin
        dx = ra_r;
        if (!dbusy) begin
          ra_nxt = (aneg_r && dres != 0) ? m_r - dres : dres;
          state_nxt = S_RB;
        end
      end
      S_RB: begin
        cmd = '{start: 1'b1, op: DOP_REM}; dx = rb_r; state_nxt = S_RBW;
      end
      S_RBW: begin
        dx = rb_r;
        if (!dbusy) begin
          rb_nxt = (bneg_r && dres != 0) ? m_r - dres : dres;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        case (func_r)
          FN_RED: res_nxt = ra_r[31:0];
          FN_ADD: begin
            tmp = ra_r + rb_r;
            res_nxt = 32'((tmp >= m_r) ? tmp - m_r : tmp);
          end
          FN_SUB: res_nxt = 32'((ra_r >= rb_r) ? ra_r - rb_r : ra_r + (m_r - rb_r));
          FN_MUL: begin
            cmd = '{start: 1'b1, op: DOP_MUL}; dx = ra_r; dy = rb_r;
            state_nxt = S_MULW;
          end
          FN_NEG: res_nxt = 32'((ra_r != 0) ? m_r - ra_r : 64'd0);
          FN_POW: begin
            acc_nxt = 64'd1; e_nxt = eb_r;
            if (bneg_r) begin
              r1_nxt = ra_r; state_nxt = S_INV_CHK;
            end else state_nxt = S_POW_BIT;
          end
          default: begin
            r1_nxt = rb_r; state_nxt = S_INV_CHK;
          end
        endcase
        r0_nxt = m_r; t0_nxt = 64'd0; t1_nxt = 64'd1;
        if (func_r == FN_POW && bneg_r) r1_nxt = ra_r;
        else if (func_r == FN_DIV || func_r == FN_INV) r1_nxt = rb_r;
      end
      S_MULW: begin
        dx = ra_r;
        if (!dbusy) begin res_nxt = dres[31:0]; state_nxt = S_OUT; end
      end
      S_INV_CHK: begin
        if (r1_r == 0) begin
          if (t0_r == 64'd0 && t1_r == 64'd1 && r0_r == m_r) begin
            err_nxt = 1'b1; res_nxt = '0; state_nxt = S_OUT;
          end else if (func_r == FN_INV) begin
            res_nxt = t0_r[31:0]; state_nxt = S_OUT;
          end else if (func_r == FN_DIV) begin
            state_nxt = S_DIV_M;
          end else begin
            ra_nxt = t0_r; state_nxt = S_POW_BIT;
          end
        end else state_nxt = S_INV_Q;
      end
      S_INV_Q: begin
        cmd = '{start: 1'b1, op: DOP_REM}; dx = r0_r; state_nxt = S_INV_QW;
      end
      S_INV_QW: begin
        dx = r0_r;
        if (!dbusy) begin q_nxt = dquo; rem_nxt = dres; state_nxt = S_INV_M; end
      end
      S_INV_M: begin
        // Quotient is below the modulus except on the first step, where r1 < m keeps it fine.
        cmd = '{start: 1'b1, op: DOP_MUL}; dx = t1_r; dy = q_r; state_nxt = S_INV_MW;
      end
      S_INV_MW: begin
        dx = t1_r;
        if (!dbusy) begin
          tmp = (t0_r >= dres) ? t0_r - dres : t0_r + (m_r - dres);
          r0_nxt = r1_r; r1_nxt = rem_r; t0_nxt = t1_r; t1_nxt = tmp;
          state_nxt = S_INV_CHK;
        end
      end
      S_DIV_M: begin
        cmd = '{start: 1'b1, op: DOP_MUL}; dx = ra_r; dy = t0_r; state_nxt = S_DIV_MW;
      end
      S_DIV_MW: begin
        dx = ra_r;
        if (!dbusy) begin res_nxt = dres[31:0]; state_nxt = S_OUT; end
      end
      S_POW_BIT: begin
        if (e_r == 0) begin
          res_nxt = 32'((m_r == 64'd1) ? 64'd0 : acc_r); state_nxt = S_OUT;
        end else if (e_r[0]) state_nxt = S_POW_AM;
        else state_nxt = S_POW_SQ;
      end
      S_POW_AM: begin
        cmd = '{start: 1'b1, op: DOP_MUL}; dx = ra_r; dy = acc_r; state_nxt = S_POW_AMW;
      end
      S_POW_AMW: begin
        dx = ra_r;
        if (!dbusy) begin acc_nxt = dres; state_nxt = S_POW_SQ; end
      end
      S_POW_SQ: begin
        cmd = '{start: 1'b1, op: DOP_MUL}; dx = ra_r; dy = ra_r; state_nxt = S_POW_SQW;
      end
      S_POW_SQW: begin
        dx = ra_r;
        if (!dbusy) begin
          ra_nxt = dres; e_nxt = {1'b0, e_r[63:1]}; state_nxt = S_POW_BIT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    func_r <= func_nxt; ra_r <= ra_nxt; rb_r <= rb_nxt; eb_r <= eb_nxt; m_r <= m_nxt;
    aneg_r <= aneg_nxt; bneg_r <= bneg_nxt;
    r0_r <= r0_nxt; r1_r <= r1_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; acc_r <= acc_nxt; e_r <= e_nxt;
    err_r <= err_nxt; res_r <= res_nxt;
  end
endmodule

// ----- hdl/modular_arithmetic_unit.sv -----
// Top level of the modular arithmetic unit.
//
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_ready   in_data (func, operand_a, operand_b)
//  out_     output     out_valid / out_ready out_data (result, error)
//  cfg_     input      cfg_valid / cfg_ready cfg_data (modulus)
//
// Reduce, add, sub and negate use the shared unit to reduce both operands; mul also runs the product on it.
// Divide and inverse run the extended Euclid algorithm, with one quotient and one product per step.
// Pow multiplies for each set exponent bit and squares for each exponent bit, plus one
// inverse first when the exponent is negative.
// Each remainder or product runs on the shared bit-serial unit.
// Reset sets the modulus to 17; no new input item is taken until the result transfer is done.
module modular_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mau_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mau_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import mau_pkg::*;

  logic [WIDTH-1:0] modulus_r, modulus_nxt;
  logic [WIDTH-1:0] cfg_v;
  du_cmd_t     cmd;
  logic [63:0] dx, dy, dm, dres, dquo;
  logic        dbusy;

  assign cfg_ready = 1'b1;
  assign cfg_v = cfg_data[WIDTH-1:0];

  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_valid && cfg_v >= WIDTH'(2)) modulus_nxt = cfg_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) modulus_r <= MOD_RESET;
    else modulus_r <= modulus_nxt;
  end

  mau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .modulus(32'(modulus_r)), .cmd, .dx, .dy, .dm, .dbusy, .dres, .dquo
  );

  mau_datapath u_dp (
    .clk, .rst_n, .cmd, .x(dx), .y(dy), .m(dm), .busy(dbusy), .res(dres), .quo(dquo)
  );
endmodule

// ----- hdl/mau_checker.sv -----
// Port checker for the modular arithmetic unit, bound to the top level.
`include "modular_arithmetic_unit_defines.svh"
module mau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mau_pkg::out_item_t out_data
);
  import mau_pkg::*;

  `MAU_ASSERT_IMP(a_excl, clk, rst_n, out_valid, !in_ready)
  `MAU_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  `MAU_ASSERT_IMP(a_err0, clk, rst_n, out_valid && out_data.error, out_data.result == 32'd0)
  `MAU_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind modular_arithmetic_unit mau_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the modular arithmetic unit with a built-in residue predictor.
`timescale 1ns / 100ps

module tb_top;
  import mau_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  logic [63:0] cur_modulus;
  out_item_t pending_results[$];
  int unsigned mismatches = 0;
  bit allow_idle = 1'b1;

  always #2 clk = ~clk;

  modular_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic logic [63:0] residue(input logic [63:0] raw, input logic [63:0] m);
    logic [63:0] r;
    if (raw[63]) begin
      r = (64'd0 - raw) % m;
      return (r != 0) ? m - r : 64'd0;
    end
    return raw % m;
  endfunction

  function automatic logic [63:0] mod_add(input logic [63:0] a, b, m);
    logic [63:0] s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic logic [63:0] mod_sub(input logic [63:0] a, b, m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [63:0] mod_mul(input logic [63:0] a, b, m);
    logic [63:0] acc;
    acc = 0;
    while (b != 0) begin
      if (b[0]) acc = mod_add(acc, a, m);
      a = mod_add(a, a, m);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] bezout_coeff(input logic [63:0] x, m, output bit err);
    logic [63:0] r0, r1, t0, t1, q, rr, tn;
    err = 1'b0;
    if (x == 0) begin
      err = 1'b1;
      return 0;
    end
    r0 = m; r1 = x; t0 = 0; t1 = 64'd1 % m;
    while (r1 != 0) begin
      q = r0 / r1;
      rr = r0 % r1;
      tn = mod_sub(t0, mod_mul(q % m, t1, m), m);
      r0 = r1; r1 = rr; t0 = t1; t1 = tn;
    end
    return t0;
  endfunction

  function automatic out_item_t modular_result(input in_item_t it);
    logic [63:0] m, a, b, r, e, base;
    bit err;
    out_item_t o;
    m = cur_modulus;
    a = residue(it.operand_a, m);
    b = residue(it.operand_b, m);
    err = 1'b0;
    r = 0;
    case (func_t'(it.func))
      FN_RED: r = a;
      FN_ADD: r = mod_add(a, b, m);
      FN_SUB: r = mod_sub(a, b, m);
      FN_MUL: r = mod_mul(a, b, m);
      FN_DIV: begin
        r = bezout_coeff(b, m, err);
        r = err ? 64'd0 : mod_mul(a, r, m);
      end
      FN_POW: begin
        e = it.operand_b;
        base = a;
        r = 64'd1 % m;
        if (e[63]) begin
          e = 64'd0 - e;
          base = bezout_coeff(base, m, err);
        end
        if (!err) begin
          while (e != 0) begin
            if (e[0]) r = mod_mul(r, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
          end
        end
      end
      FN_INV: r = bezout_coeff(b, m, err);
      default: r = (a != 0) ? m - a : 64'd0;
    endcase
    if (err) r = 0;
    o.result = r[31:0];
    o.error = err;
    return o;
  endfunction

  task automatic send_item(input func_t f, input logic [63:0] a, input logic [63:0] b);
    in_item_t it;
    int gap;
    gap = allow_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.func = f;
    it.operand_a = a;
    it.operand_b = b;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(modular_result(it));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [31:0] v);
    drain_results();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (v >= 2) cur_modulus = {32'd0, v};
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 40));
      2: return -64'($urandom_range(0, 40));
      3: return {1'b1, 63'd0};
      4: return {1'b0, {63{1'b1}}};
      default: return {{32{$urandom_range(0, 1) == 1}}, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_exponent();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return -64'($urandom_range(0, 300));
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic test_operand_extremes();
    logic [63:0] ext[6];
    ext = '{64'd0, 64'd1, {64{1'b1}}, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 64'd16};
    for (int i = 0; i < 6; i++) begin
      send_item(FN_RED, ext[i], ext[5 - i]);
      send_item(FN_ADD, ext[i], ext[i]);
      send_item(FN_MUL, ext[i], ext[5 - i]);
    end
  endtask

  task automatic test_special_cases();
    send_item(FN_SUB, 64'd3, 64'd5);
    send_item(FN_NEG, 64'd0, 64'd0);
    send_item(FN_NEG, 64'd5, 64'd0);
    send_item(FN_DIV, 64'd7, 64'd17);
    send_item(FN_INV, 64'd0, 64'd0);
    send_item(FN_INV, 64'd0, 64'd3);
    send_item(FN_DIV, 64'd9, -64'd4);
    send_item(FN_POW, 64'd0, -64'd1);
    send_item(FN_POW, 64'd3, 64'd0);
    send_item(FN_POW, 64'd3, {1'b1, 63'd0});
    send_item(FN_POW, 64'd5, -64'd3);
  endtask

  task automatic test_modulus_settings();
    write_modulus(32'd1);
    write_modulus(32'd0);
    send_item(FN_ADD, 64'd20, 64'd5);
    write_modulus(32'd2);
    send_item(FN_INV, 64'd0, 64'd1);
    send_item(FN_POW, -64'd1, 64'd11);
    write_modulus(32'd12);
    send_item(FN_INV, 64'd0, 64'd4);
    send_item(FN_DIV, 64'd5, 64'd6);
    write_modulus(32'hFFFF_FFFF);
    send_item(FN_MUL, -64'd1, -64'd1);
    send_item(FN_INV, 64'd0, 64'd3);
  endtask

  task automatic test_random_items(input int count);
    logic [63:0] mods[5];
    mods = '{64'd17, 64'd2, 64'd1000003, 64'hFFFF_FFFF, 64'd0};
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        mods[4] = 64'($urandom_range(2, 32'hFFFF_FFFF));
        write_modulus(mods[(i / 25) % 5][31:0]);
      end
      allow_idle = (i % 40) < 30;
      if ($urandom_range(0, 5) == 0)
        send_item(FN_POW, rand64(), rand_exponent());
      else
        send_item(func_t'($urandom_range(0, 7)), rand64(), rand64());
      if (i == count / 2) drain_results();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, actual result=%0d error=%0b",
                   $time, out_data.result, out_data.error);
          mismatches++;
        end else begin
          if (out_data.result !== pending_results[0].result) begin
            $display("%0t: result mismatch, expected %0d actual %0d",
                     $time, pending_results[0].result, out_data.result);
            mismatches++;
          end
          if (out_data.error !== pending_results[0].error) begin
            $display("%0t: error mismatch, expected %0b actual %0b",
                     $time, pending_results[0].error, out_data.error);
            mismatches++;
          end
          void'(pending_results.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
    end
  end

  initial begin
    cur_modulus = 64'd17;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operand_extremes();
    test_special_cases();
    test_modulus_settings();
    test_random_items(103);
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mau_pkg.sv
hdl/mau_datapath.sv
hdl/mau_ctrl.sv
hdl/modular_arithmetic_unit.sv
hdl/mau_checker.sv
tb/sv/tb_top.sv
